// File: sv/toy_register_machine_execute_top_assert.svh
// Assertion macros for the register machine execute block.
`ifndef TOY_REGISTER_MACHINE_EXECUTE_TOP_ASSERT_SVH
`define TOY_REGISTER_MACHINE_EXECUTE_TOP_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define TRME_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define TRME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/trme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trme_pkg;

   // Opcodes
   typedef enum logic [2:0] {
      OP_MOV = 3'd0,
      OP_ADD = 3'd1,
      OP_SUB = 3'd2,
      OP_JMP = 3'd3,
      OP_JPN = 3'd4,
      OP_PRN = 3'd5,
      OP_HLT = 3'd6
   } op_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_HALT    = 3'd1,
      ST_BADJUMP = 3'd2,
      ST_BADMEM  = 3'd3,
      ST_ILLEGAL = 3'd4
   } status_type;

   // Operand forms
   localparam logic [2:0] MOV_MEM_TO_REG = 3'd0;
   localparam logic [2:0] MOV_REG_TO_MEM = 3'd1;
   localparam logic [2:0] MOV_REG_TO_REG = 3'd2;
   localparam logic [2:0] MOV_IMM_TO_REG = 3'd3;
   localparam logic [2:0] MOV_IMM_TO_MEM = 3'd4;
   localparam logic [2:0] ALU_SRC_REG    = 3'd0;
   localparam logic [2:0] ALU_SRC_IMM    = 3'd1;
   localparam logic [2:0] ALU_SRC_MEM    = 3'd2;
   localparam logic [2:0] JMP_ALWAYS     = 3'd0;
   localparam logic [2:0] JMP_IF_ZERO    = 3'd1;
   localparam logic [2:0] PRN_REG        = 3'd0;
   localparam logic [2:0] PRN_MEM        = 3'd1;
   localparam logic [2:0] PRN_IMM        = 3'd2;

   // Register numbers run 1..REG_COUNT
   localparam int unsigned REG_COUNT = 5;
   localparam logic [2:0]  REG_LAST  = 3'd5;
   localparam logic [8:0]  LENGTH_RESET = 9'd256;

   typedef struct packed {
      logic [2:0]         op;
      logic [2:0]         mode;
      logic [2:0]         reg_a;
      logic [2:0]         reg_b;
      logic [7:0]         mem_address;
      logic signed [31:0] immediate;
      logic [8:0]         target_line;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      logic               print_valid;
      logic signed [31:0] print_value;
      logic [8:0]         next_line;
   } rsp_item_type;

   // State write-back from the execute stage
   typedef struct packed {
      logic        rf_we;
      logic [2:0]  rf_idx;
      logic [31:0] rf_data;
      logic        mem_we;
      logic [7:0]  mem_address;
      logic [31:0] mem_data;
   } wb_type;

   function automatic logic reg_ok(input logic [2:0] r);
      reg_ok = (r != 3'd0) && (r <= REG_LAST);
   endfunction

endpackage

`default_nettype wire

// File: sv/trme_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface trme_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic [2:0]         mode;
   logic [2:0]         reg_a;
   logic [2:0]         reg_b;
   logic [7:0]         mem_address;
   logic signed [31:0] immediate;
   logic [8:0]         target_line;

   modport source (
      output valid, op, mode, reg_a, reg_b, mem_address, immediate, target_line,
      input  ready
   );
   modport sink (
      input  valid, op, mode, reg_a, reg_b, mem_address, immediate, target_line,
      output ready
   );
endinterface

`default_nettype wire

// File: sv/trme_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface trme_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic               print_valid;
   logic signed [31:0] print_value;
   logic [8:0]         next_line;

   modport source (
      output valid, status, print_valid, print_value, next_line,
      input  ready
   );
   modport sink (
      input  valid, status, print_valid, print_value, next_line,
      output ready
   );
endinterface

`default_nettype wire

// File: sv/trme_operand.sv
`timescale 1ns / 1ps
`default_nettype none

// Input register: holds the instruction, owns the register file and the
// data memory, and captures operands at accept with write-back forwarding.
module trme_operand #(
   parameter int unsigned MEM_WORDS = 64
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        load,
   input  wire trme_pkg::req_item_type item,
   input  wire trme_pkg::wb_type      wb,
   output trme_pkg::req_item_type     item_q,
   output logic [31:0]                a_val,
   output logic [31:0]                b_val,
   output logic [31:0]                m_val
);

   localparam int unsigned MemIdxW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam logic [8:0]  MemWords9 = 9'(MEM_WORDS);

   trme_pkg::req_item_type item_ff;
   logic [31:0]  rf_ff [trme_pkg::REG_COUNT];
   logic [31:0]  mem [MEM_WORDS];
   logic [MEM_WORDS-1:0] mvld_ff;
   logic [31:0]  a_ff, b_ff;
   logic [31:0]  a_in, b_in;
   logic [31:0]  mrd_ff;
   logic         mhit_ff, mhit_in;
   logic         mbyp_ff, mbyp_in;
   logic [31:0]  mbyp_data_ff;
   logic [MemIdxW-1:0] rd_idx, wr_idx;
   logic         rd_ok;
   logic [2:0]   a_idx, b_idx;

   assign rd_idx = item.mem_address[MemIdxW-1:0];
   assign wr_idx = wb.mem_address[MemIdxW-1:0];
   assign rd_ok  = {1'b0, item.mem_address} < MemWords9;
   assign a_idx  = item.reg_a - 3'd1;
   assign b_idx  = item.reg_b - 3'd1;

   // Pick register operands, forwarding a write landing this cycle
   always_comb begin
      a_in = 32'd0;
      b_in = 32'd0;
      if (trme_pkg::reg_ok(item.reg_a)) begin
         if (wb.rf_we && wb.rf_idx == a_idx) a_in = wb.rf_data;
         else a_in = rf_ff[a_idx];
      end
      if (trme_pkg::reg_ok(item.reg_b)) begin
         if (wb.rf_we && wb.rf_idx == b_idx) b_in = wb.rf_data;
         else b_in = rf_ff[b_idx];
      end
   end

   // Resolve memory forwarding and never-written words
   always_comb begin
      mbyp_in = wb.mem_we && rd_ok && (wb.mem_address == item.mem_address);
      mhit_in = rd_ok && mvld_ff[rd_idx];
   end

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < trme_pkg::REG_COUNT; i++) rf_ff[i] <= 32'd0;
      end else if (wb.rf_we) begin
         rf_ff[wb.rf_idx] <= wb.rf_data;
      end
   end

   // Data memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wb.mem_we) mem[wr_idx] <= wb.mem_data;
      if (load && rd_ok) mrd_ff <= mem[rd_idx];
   end

   // Track written words so reset reads back zero
   always_ff @(posedge clock) begin
      if (reset) begin
         mvld_ff <= '0;
      end else if (wb.mem_we) begin
         mvld_ff[wr_idx] <= 1'b1;
      end
   end

   // Capture instruction and operands on accept
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff      <= item;
         a_ff         <= a_in;
         b_ff         <= b_in;
         mhit_ff      <= mhit_in;
         mbyp_ff      <= mbyp_in;
         mbyp_data_ff <= wb.mem_data;
      end
   end

   assign item_q = item_ff;
   assign a_val  = a_ff;
   assign b_val  = b_ff;
   assign m_val  = mbyp_ff ? mbyp_data_ff : (mhit_ff ? mrd_ff : 32'd0);

endmodule

`default_nettype wire

// File: sv/trme_exec.sv
`timescale 1ns / 1ps
`default_nettype none

// Execute stage: decode checks, moves, add/subtract, jump resolution, prints; owns the
// line counter, the halt flag and the result register.
module trme_exec #(
   parameter int unsigned MEM_WORDS = 64
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         commit,
   input  wire trme_pkg::req_item_type  item,
   input  wire [31:0]                  a_val,
   input  wire [31:0]                  b_val,
   input  wire [31:0]                  m_val,
   input  wire [8:0]                   limit,
   output trme_pkg::wb_type            wb,
   output trme_pkg::rsp_item_type      result
);

   localparam logic [8:0] MemWords9 = 9'(MEM_WORDS);

   trme_pkg::rsp_item_type result_ff, result_in;
   logic [8:0]  line_index_ff, line_index_in;
   logic        halted_ff, halted_in;

   trme_pkg::status_type st;
   logic        ra_ok, rb_ok, m_ok;
   logic        taken, set_halt;
   logic        rf_we, mem_we;
   logic [2:0]  rf_idx;
   logic [31:0] rf_data, mem_data, src;
   logic        pv;
   logic [31:0] pval;
   logic [8:0]  nxt;

   // Decode and execute one instruction
   always_comb begin
      ra_ok    = trme_pkg::reg_ok(item.reg_a);
      rb_ok    = trme_pkg::reg_ok(item.reg_b);
      m_ok     = {1'b0, item.mem_address} < MemWords9;
      st       = trme_pkg::ST_OK;
      taken    = 1'b0;
      set_halt = 1'b0;
      rf_we    = 1'b0;
      rf_idx   = item.reg_a - 3'd1;
      rf_data  = 32'd0;
      mem_we   = 1'b0;
      mem_data = 32'd0;
      src      = 32'd0;
      pv       = 1'b0;
      pval     = 32'd0;
      nxt      = line_index_ff + 9'd1;

      case (item.op)
         trme_pkg::OP_MOV: begin
            if (item.mode > trme_pkg::MOV_IMM_TO_MEM) begin
               st = trme_pkg::ST_ILLEGAL;
            end else if ((item.mode <= trme_pkg::MOV_IMM_TO_REG && !ra_ok) ||
                         (item.mode == trme_pkg::MOV_REG_TO_REG && !rb_ok)) begin
               st = trme_pkg::ST_ILLEGAL;
            end else if ((item.mode == trme_pkg::MOV_MEM_TO_REG ||
                          item.mode == trme_pkg::MOV_REG_TO_MEM ||
                          item.mode == trme_pkg::MOV_IMM_TO_MEM) && !m_ok) begin
               st = trme_pkg::ST_BADMEM;
            end else begin
               case (item.mode)
                  trme_pkg::MOV_MEM_TO_REG: begin
                     rf_we   = 1'b1;
                     rf_data = m_val;
                  end
                  trme_pkg::MOV_REG_TO_MEM: begin
                     mem_we   = 1'b1;
                     mem_data = a_val;
                  end
                  trme_pkg::MOV_REG_TO_REG: begin
                     rf_we   = 1'b1;
                     rf_idx  = item.reg_b - 3'd1;
                     rf_data = a_val;
                  end
                  trme_pkg::MOV_IMM_TO_REG: begin
                     rf_we   = 1'b1;
                     rf_data = item.immediate;
                  end
                  default: begin
                     mem_we   = 1'b1;
                     mem_data = item.immediate;
                  end
               endcase
            end
         end
         trme_pkg::OP_ADD, trme_pkg::OP_SUB: begin
            if (item.mode > trme_pkg::ALU_SRC_MEM || !ra_ok ||
                (item.mode == trme_pkg::ALU_SRC_REG && !rb_ok)) begin
               st = trme_pkg::ST_ILLEGAL;
            end else if (item.mode == trme_pkg::ALU_SRC_MEM && !m_ok) begin
               st = trme_pkg::ST_BADMEM;
            end else begin
               case (item.mode)
                  trme_pkg::ALU_SRC_REG: src = b_val;
                  trme_pkg::ALU_SRC_IMM: src = item.immediate;
                  default:               src = m_val;
               endcase
               rf_we   = 1'b1;
               rf_data = (item.op == trme_pkg::OP_ADD) ? a_val + src : a_val - src;
            end
         end
         trme_pkg::OP_JMP: begin
            if (item.mode > trme_pkg::JMP_IF_ZERO ||
                (item.mode == trme_pkg::JMP_IF_ZERO && !ra_ok)) begin
               st = trme_pkg::ST_ILLEGAL;
            end else begin
               taken = (item.mode == trme_pkg::JMP_ALWAYS) || (a_val == 32'd0);
            end
         end
         trme_pkg::OP_JPN: begin
            if (!ra_ok) st = trme_pkg::ST_ILLEGAL;
            else taken = (a_val == 32'd0) || a_val[31];
         end
         trme_pkg::OP_PRN: begin
            if (item.mode > trme_pkg::PRN_IMM ||
                (item.mode == trme_pkg::PRN_REG && !ra_ok)) begin
               st = trme_pkg::ST_ILLEGAL;
            end else if (item.mode == trme_pkg::PRN_MEM && !m_ok) begin
               st = trme_pkg::ST_BADMEM;
            end else begin
               pv = 1'b1;
               case (item.mode)
                  trme_pkg::PRN_REG: pval = a_val;
                  trme_pkg::PRN_MEM: pval = m_val;
                  default:           pval = item.immediate;
               endcase
            end
         end
         trme_pkg::OP_HLT: begin
            st       = trme_pkg::ST_HALT;
            set_halt = 1'b1;
         end
         default: begin
            st = trme_pkg::ST_ILLEGAL;
         end
      endcase

      // Resolve a taken jump against the program length
      if (taken) begin
         if (item.target_line == 9'd0 || item.target_line > limit) begin
            st = trme_pkg::ST_BADJUMP;
         end else begin
            nxt = item.target_line - 9'd1;
         end
      end

      // Drop all effects once halted
      if (halted_ff) begin
         st       = trme_pkg::ST_HALT;
         set_halt = 1'b0;
         pv       = 1'b0;
         pval     = 32'd0;
      end
   end

   // Gate state updates on the committing transaction
   always_comb begin
      wb.rf_we       = commit && (st == trme_pkg::ST_OK) && rf_we;
      wb.rf_idx      = rf_idx;
      wb.rf_data     = rf_data;
      wb.mem_we      = commit && (st == trme_pkg::ST_OK) && mem_we;
      wb.mem_address = item.mem_address;
      wb.mem_data    = mem_data;
   end

   // Next line counter, halt flag and result
   always_comb begin
      line_index_in = (st == trme_pkg::ST_OK) ? nxt : line_index_ff;
      halted_in     = halted_ff || set_halt;
      result_in.status      = st;
      result_in.print_valid = pv;
      result_in.print_value = pval;
      result_in.next_line   = line_index_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_index_ff <= 9'd0;
         halted_ff     <= 1'b0;
      end else if (commit) begin
         line_index_ff <= line_index_in;
         halted_ff     <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// File: sv/toy_register_machine_execute_top.sv
// Register machine execute block.
// Pipeline: an input register, then the result register once the result slot frees up.
// Throughput: one instruction per cycle unless the response stalls; operands are read from
// the register file and data memory at accept and forwarded from the write-back in flight.
// Reset (synchronous): registers, line index, halt flag cleared, memory reads
// as zero at once via per-word valid bits, program_length set to 256.
`timescale 1ns / 1ps
`default_nettype none
`include "toy_register_machine_execute_top_assert.svh"

module toy_register_machine_execute_top #(
   parameter int unsigned MEM_WORDS = 64,
   parameter int unsigned MAX_LINES = 256
) (
   input  wire        clock,
   input  wire        reset,
   trme_req_if.sink   req_bus,
   trme_rsp_if.source rsp_bus,
   input  wire        csr_wr_en,
   input  wire [8:0]  csr_wr_data
);

   localparam logic [8:0] MaxLines9 = 9'(MAX_LINES);

   logic [8:0] program_length_ff;
   logic [8:0] limit;
   logic       s1_vld_ff, s1_vld_in;
   logic       out_vld_ff, out_vld_in;
   logic       advance, accept;

   trme_pkg::req_item_type item, item_q;
   trme_pkg::wb_type       wb;
   trme_pkg::rsp_item_type result;
   logic [31:0] a_val, b_val, m_val;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) program_length_ff <= trme_pkg::LENGTH_RESET;
      else if (csr_wr_en) program_length_ff <= csr_wr_data;
   end

   assign limit = (program_length_ff > MaxLines9) ? MaxLines9 : program_length_ff;

   // Handshake: advance the input stage when the result slot frees up
   assign advance       = s1_vld_ff && (!out_vld_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_vld_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_vld_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_vld_ff);
      out_vld_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Pack the request transaction
   always_comb begin
      item.op          = req_bus.op;
      item.mode        = req_bus.mode;
      item.reg_a       = req_bus.reg_a;
      item.reg_b       = req_bus.reg_b;
      item.mem_address = req_bus.mem_address;
      item.immediate   = req_bus.immediate;
      item.target_line = req_bus.target_line;
   end

   trme_operand #(
      .MEM_WORDS (MEM_WORDS)
   ) u_operand (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .item   (item),
      .wb     (wb),
      .item_q (item_q),
      .a_val  (a_val),
      .b_val  (b_val),
      .m_val  (m_val)
   );

   trme_exec #(
      .MEM_WORDS (MEM_WORDS)
   ) u_exec (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .item   (item_q),
      .a_val  (a_val),
      .b_val  (b_val),
      .m_val  (m_val),
      .limit  (limit),
      .wb     (wb),
      .result (result)
   );

   // Drive the response transaction
   assign rsp_bus.valid       = out_vld_ff;
   assign rsp_bus.status      = result.status;
   assign rsp_bus.print_valid = result.print_valid;
   assign rsp_bus.print_value = result.print_value;
   assign rsp_bus.next_line   = result.next_line;

   `TRME_ASSERT_NEXT(a_commit_shows, clock, reset, advance, out_vld_ff,
      "committed instruction did not produce a response")
   `TRME_ASSERT_NOW(a_no_overrun, clock, reset, accept && s1_vld_ff, advance,
      "request accepted while input stage stalled")
   `TRME_ASSERT_NOW(a_print_ok, clock, reset, out_vld_ff && rsp_bus.print_valid,
      rsp_bus.status == trme_pkg::ST_OK, "print reported with non-ok status")
   `TRME_ASSERT_NOW(a_err_quiet, clock, reset,
      out_vld_ff && (rsp_bus.status != trme_pkg::ST_OK),
      !rsp_bus.print_valid && (rsp_bus.print_value == 32'sd0),
      "failed instruction reported a print value")

endmodule

`default_nettype wire
